// ----- rtl/mfde_pkg.sv -----
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome frame buffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned PAGES_DEF   = 8;
  localparam int unsigned BYTE_W      = 8;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned IN_FIELDS_W = 35;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PIXEL = 3'd0,
    FN_LINE  = 3'd1,
    FN_BOX   = 3'd2,
    FN_CLEAR = 3'd3,
    FN_WRITE = 3'd4,
    FN_READ  = 3'd5
  } func_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       dot;
    logic [5:0] y_b;
    logic [6:0] x_b;
    logic [5:0] y_a;
    logic [6:0] x_a;
  } in_fields_t;

  typedef struct packed {
    logic       load;
    logic       clr_start;
    logic       clr_step;
    logic       setup;
    logic [1:0] edge_sel;
    logic       pix_rd;
    logic       pix_wr;
    logic       pix_adv;
    logic       byte_wr;
    logic       byte_rd;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pix_on;
    logic pix_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/mono_framebuffer_draw_engine.sv -----
// Commands run one at a time; every store access goes through the single RAM port pair,
// with one read-modify-write per on-screen pixel.
// Clear walks COLUMNS*PAGES bytes, one a cycle (1024 at default size); reset runs the
// same sweep with input held off.
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Page organised monochrome frame store with pixel, line, box and byte access.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
  parameter int unsigned COLUMNS = mfde_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = mfde_pkg::PAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // x_a[6:0], y_a[12:7], x_b[19:13], y_b[25:20], dot[26], data_byte[34:27]
  input  logic [mfde_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // func[2:0]
  input  logic [mfde_pkg::FUNC_W-1:0]       s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // read_data[7:0]
  output logic [mfde_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mfde_pkg::ctl_cmd_t             ctl_cmd;
  mfde_pkg::dp_stat_t             dp_stat;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [mfde_pkg::BYTE_W-1:0]    ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [mfde_pkg::BYTE_W-1:0]    ram_rdata;

  mfde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  mfde_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .in_func_i   (s_axis_tuser_i),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  mfde_ram #(
    .WIDTH (mfde_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.out_load |-> dp_stat.out_free)
    else $error("result loaded while output register busy");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ({1'b0, ram_waddr} < (AW + 1)'(DEPTH)))
    else $error("store write beyond depth");

  a_clr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.clr_step |-> !s_axis_tready_o)
    else $error("input ready during clear sweep");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(ctl_cmd.out_load))
    else $error("result valid without load");
`endif

endmodule

// ----- rtl/mfde_ram.sv -----
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mfde_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfde_ctrl
// Command sequencer: clear sweep, line and box stepping, byte access.
// ----------------------------------------------------------------------------
module mfde_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [mfde_pkg::FUNC_W-1:0]   in_func_i,
  output logic                          in_ready_o,
  input  mfde_pkg::dp_stat_t            stat_i,
  output mfde_pkg::ctl_cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SETUP,
    ST_PRD,
    ST_PWR,
    ST_BWR,
    ST_BRD,
    ST_BWAIT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] edge_q, edge_d;
  logic       box_q, box_d;
  logic       line_done;

  always_comb begin
    state_d    = state_q;
    edge_d     = edge_q;
    box_d      = box_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    line_done  = 1'b0;
    cmd_o.edge_sel = edge_q;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          edge_d     = 2'd0;
          box_d      = 1'b0;
          case (mfde_pkg::func_e'(in_func_i))
            mfde_pkg::FN_PIXEL, mfde_pkg::FN_LINE: begin
              state_d = ST_SETUP;
            end
            mfde_pkg::FN_BOX: begin
              box_d   = 1'b1;
              state_d = ST_SETUP;
            end
            mfde_pkg::FN_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = ST_CLR;
            end
            mfde_pkg::FN_WRITE: begin
              state_d = ST_BWR;
            end
            mfde_pkg::FN_READ: begin
              state_d = ST_BRD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_PRD;
      end
      ST_PRD: begin
        if (stat_i.pix_on) begin
          cmd_o.pix_rd = 1'b1;
          state_d      = ST_PWR;
        end else begin
          cmd_o.pix_adv = 1'b1;
          line_done     = stat_i.pix_last;
        end
      end
      ST_PWR: begin
        cmd_o.pix_wr  = 1'b1;
        cmd_o.pix_adv = 1'b1;
        line_done     = stat_i.pix_last;
        state_d       = ST_PRD;
      end
      ST_BWR: begin
        cmd_o.byte_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_BRD: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = ST_BWAIT;
      end
      ST_BWAIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (line_done) begin
      if (box_q && (edge_q != 2'd3)) begin
        edge_d  = edge_q + 2'd1;
        state_d = ST_SETUP;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      edge_q  <= 2'd0;
      box_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      edge_q  <= edge_d;
      box_q   <= box_d;
    end
  end

endmodule

// ----- rtl/mfde_datapath.sv -----
// ----------------------------------------------------------------------------
// mfde_datapath
// Command register, line stepper, address and mask logic, clear counter and
// result register of the draw engine.
// ----------------------------------------------------------------------------
module mfde_datapath #(
  parameter int unsigned COLUMNS = mfde_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = mfde_pkg::PAGES_DEF,
  localparam int unsigned DEPTH  = COLUMNS * PAGES,
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mfde_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic [mfde_pkg::FUNC_W-1:0]       in_func_i,
  input  mfde_pkg::ctl_cmd_t                cmd_i,
  output mfde_pkg::dp_stat_t                stat_o,
  output logic                              ram_we_o,
  output logic [AW-1:0]                     ram_waddr_o,
  output logic [mfde_pkg::BYTE_W-1:0]       ram_wdata_o,
  output logic                              ram_re_o,
  output logic [AW-1:0]                     ram_raddr_o,
  input  logic [mfde_pkg::BYTE_W-1:0]       ram_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mfde_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int unsigned ROWS  = PAGES * 8;
  localparam int unsigned MUL_W = AW + 9;

  mfde_pkg::in_fields_t              fld_q;
  logic [mfde_pkg::FUNC_W-1:0]       func_q;

  // endpoint selection
  logic [7:0] xa8, xb8, ya8, yb8, xe8, ye8;
  logic [7:0] x0, y0, x1, y1;

  // line setup
  logic [7:0] adx, ady;
  logic       xmaj, swp;
  logic [7:0] maj_s, min_s, min_e, rem_s;
  logic [8:0] len_s, span_s;

  // stepper state
  logic [7:0] maj_q, base_q, q_q, rem_q;
  logic [8:0] r_q, len_q, span_q;
  logic       xmaj_q, neg_q;
  logic [9:0] r_sum;

  // current pixel
  logic [7:0]         min_c, pix_x, pix_y;
  logic [MUL_W-1:0]   pix_full, byte_full;
  logic [AW-1:0]      pix_addr, byte_addr;
  logic [7:0]         pix_mask, pix_new;
  logic               byte_ok;

  logic [AW-1:0]      clr_q;
  logic               out_valid_q;
  logic [7:0]         out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fld_q  <= mfde_pkg::in_fields_t'(in_data_i[mfde_pkg::IN_FIELDS_W-1:0]);
      func_q <= in_func_i;
    end
  end

  assign xa8 = {1'b0, fld_q.x_a};
  assign xb8 = {1'b0, fld_q.x_b};
  assign ya8 = {2'b00, fld_q.y_a};
  assign yb8 = {2'b00, fld_q.y_b};
  assign xe8 = xa8 + xb8;
  assign ye8 = ya8 + yb8;

  always_comb begin
    x0 = xa8;
    y0 = ya8;
    x1 = xa8;
    y1 = ya8;
    case (mfde_pkg::func_e'(func_q))
      mfde_pkg::FN_LINE: begin
        x1 = xb8;
        y1 = yb8;
      end
      mfde_pkg::FN_BOX: begin
        case (cmd_i.edge_sel)
          2'd0: begin
            x1 = xe8;
          end
          2'd1: begin
            y0 = ye8;
            x1 = xe8;
            y1 = ye8;
          end
          2'd2: begin
            y1 = ye8;
          end
          default: begin
            x0 = xe8;
            x1 = xe8;
            y1 = ye8;
          end
        endcase
      end
      default: begin
        x1 = xa8;
      end
    endcase
  end

  always_comb begin
    adx  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    ady  = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    xmaj = (ady < adx);
    if (xmaj) begin
      swp    = (x1 < x0);
      maj_s  = swp ? x1 : x0;
      min_s  = swp ? y1 : y0;
      min_e  = swp ? y0 : y1;
      rem_s  = adx;
      len_s  = {1'b0, adx} + 9'd1;
      span_s = {1'b0, ady} + 9'd1;
    end else begin
      swp    = (y1 < y0);
      maj_s  = swp ? y1 : y0;
      min_s  = swp ? x1 : x0;
      min_e  = swp ? x0 : x1;
      rem_s  = ady;
      len_s  = {1'b0, ady} + 9'd1;
      span_s = {1'b0, adx} + 9'd1;
    end
  end

  assign r_sum = {1'b0, r_q} + {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      maj_q  <= maj_s;
      base_q <= min_s;
      q_q    <= 8'd0;
      r_q    <= 9'd0;
      rem_q  <= rem_s;
      len_q  <= len_s;
      span_q <= span_s;
      xmaj_q <= xmaj;
      neg_q  <= (min_e < min_s);
    end else if (cmd_i.pix_adv) begin
      maj_q <= maj_q + 8'd1;
      rem_q <= rem_q - 8'd1;
      if (r_sum >= {1'b0, len_q}) begin
        r_q <= 9'(r_sum - {1'b0, len_q});
        q_q <= q_q + 8'd1;
      end else begin
        r_q <= r_sum[8:0];
      end
    end
  end

  assign min_c    = neg_q ? (base_q - q_q) : (base_q + q_q);
  assign pix_x    = xmaj_q ? maj_q : min_c;
  assign pix_y    = xmaj_q ? min_c : maj_q;
  assign pix_full = MUL_W'(pix_y[7:3]) * MUL_W'(COLUMNS) + MUL_W'(pix_x);
  assign pix_addr = pix_full[AW-1:0];
  assign pix_mask = 8'd1 << pix_y[2:0];
  assign pix_new  = fld_q.dot ? (ram_rdata_i | pix_mask) : (ram_rdata_i & ~pix_mask);

  assign byte_ok   = ({2'b00, fld_q.x_a} < 9'(COLUMNS)) &&
                     ({2'b00, fld_q.y_a[5:3]} < 5'(PAGES));
  assign byte_full = MUL_W'(fld_q.y_a[5:3]) * MUL_W'(COLUMNS) + MUL_W'(fld_q.x_a);
  assign byte_addr = byte_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_comb begin
    ram_we_o    = cmd_i.clr_step || cmd_i.pix_wr || (cmd_i.byte_wr && byte_ok);
    ram_waddr_o = byte_addr;
    ram_wdata_o = fld_q.data_byte;
    if (cmd_i.clr_step) begin
      ram_waddr_o = clr_q;
      ram_wdata_o = '0;
    end else if (cmd_i.pix_wr) begin
      ram_waddr_o = pix_addr;
      ram_wdata_o = pix_new;
    end
    ram_re_o    = cmd_i.pix_rd || (cmd_i.byte_rd && byte_ok);
    ram_raddr_o = cmd_i.pix_rd ? pix_addr : byte_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= byte_ok ? ram_rdata_i : 8'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign stat_o.clr_last = (clr_q == AW'(DEPTH - 1));
  assign stat_o.pix_on   = ({1'b0, pix_x} < 9'(COLUMNS)) && ({1'b0, pix_y} < 9'(ROWS));
  assign stat_o.pix_last = (rem_q == 8'd0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the monochrome frame buffer draw engine. A shadow
// frame store follows every accepted command, and each byte read
// result is checked against the shadow copy. Directed corner commands come
// first, then random drawing mixed with reads near recent drawing. Sender
// bursts and receiver stall patterns vary throughout the run.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfde_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int ROWS        = PAGES_DEF * 8;
  localparam int STORE_BYTES = COLUMNS_DEF * PAGES_DEF;
  localparam int N_RANDOM    = 1425;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE      = 1500;
  localparam int LIMIT       = 2000000;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0] func;
    in_fields_t        f;
    bit                wait_drain;
    bit                rx_hold;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  cmd_t       cmd_q[$];
  logic [7:0] read_data_q[$];
  logic [7:0] fb_mem[0:STORE_BYTES-1];
  cmd_t       cur;
  int         err_cnt = 0;
  int         last_x = 0;
  int         last_y = 0;
  logic       hold_toggle = 1'b0;

  mono_framebuffer_draw_engine u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow frame store

  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x < 0 || y < 0 || x >= COLS || y >= ROWS) return;
    idx = (y / 8) * COLS + x;
    fb_mem[idx][y % 8] = on;
  endfunction

  function automatic void draw_span(int x0, int y0, int x1, int y1, bit on);
    int w, h, sx, sy, ex, ey, step;
    w = (x1 > x0 ? x1 - x0 : x0 - x1) + 1;
    h = (y1 > y0 ? y1 - y0 : y0 - y1) + 1;
    if (h < w) begin
      if (x1 < x0) begin
        sx = x1; sy = y1; ey = y0;
      end else begin
        sx = x0; sy = y0; ey = y1;
      end
      step = (ey < sy) ? -1 : 1;
      for (int k = 0; k < w; k++) plot(sx + k, sy + step * ((k * h) / w), on);
    end else begin
      if (y1 < y0) begin
        sx = x1; sy = y1; ex = x0;
      end else begin
        sx = x0; sy = y0; ex = x1;
      end
      step = (ex < sx) ? -1 : 1;
      for (int k = 0; k < h; k++) plot(sx + step * ((k * w) / h), sy + k, on);
    end
  endfunction

  function automatic void render_command(cmd_t c);
    int  xa, ya, xb, yb, idx;
    bit  on, byte_ok;
    xa = int'(c.f.x_a);
    ya = int'(c.f.y_a);
    xb = int'(c.f.x_b);
    yb = int'(c.f.y_b);
    on = c.f.dot;
    byte_ok = xa < COLS && (ya / 8) < PAGES_DEF;
    idx = (ya / 8) * COLS + xa;
    case (c.func)
      FN_PIXEL: plot(xa, ya, on);
      FN_LINE:  draw_span(xa, ya, xb, yb, on);
      FN_BOX: begin
        draw_span(xa, ya, xa + xb, ya, on);
        draw_span(xa, ya + yb, xa + xb, ya + yb, on);
        draw_span(xa, ya, xa, ya + yb, on);
        draw_span(xa + xb, ya, xa + xb, ya + yb, on);
      end
      FN_CLEAR: foreach (fb_mem[i]) fb_mem[i] = 8'h00;
      FN_WRITE: if (byte_ok) fb_mem[idx] = c.f.data_byte;
      FN_READ:  read_data_q.push_back(byte_ok ? fb_mem[idx] : 8'h00);
      default: ;
    endcase
  endfunction

  // Stimulus

  function automatic cmd_t mk(logic [FUNC_W-1:0] fn, int xa, int ya, int xb, int yb,
                              bit dot, logic [7:0] db);
    cmd_t c;
    c.func        = fn;
    c.f.x_a       = xa[6:0];
    c.f.y_a       = ya[5:0];
    c.f.x_b       = xb[6:0];
    c.f.y_b       = yb[5:0];
    c.f.dot       = dot;
    c.f.data_byte = db;
    c.wait_drain  = 1'b0;
    c.rx_hold     = 1'b0;
    return c;
  endfunction

  function automatic int near(int base, int spread, int maxv);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   r, xa, ya, xb, yb;
    r  = $urandom_range(0, 99);
    xa = $urandom_range(0, 127);
    ya = $urandom_range(0, 63);
    xb = $urandom_range(0, 127);
    yb = $urandom_range(0, 63);
    c  = mk(FN_READ, xa, ya, xb, yb, $urandom_range(0, 9) < 7, $urandom_range(0, 255));
    if (r < 30 || r >= 91) begin
      if ($urandom_range(0, 99) < 65) begin
        c.f.x_a = 7'(near(last_x, 4, 127));
        c.f.y_a = 6'(near(last_y, 8, 63));
      end
    end else if (r < 45) begin
      c.func = FN_PIXEL;
      if ($urandom_range(0, 1) == 1) begin
        c.f.x_a = 7'(near(last_x, 6, 127));
        c.f.y_a = 6'(near(last_y, 6, 63));
      end
      last_x = c.f.x_a;
      last_y = c.f.y_a;
    end else if (r < 65) begin
      c.func = FN_LINE;
      if ($urandom_range(0, 3) != 0) begin
        c.f.x_b = 7'(near(xa, 12, 127));
        c.f.y_b = 6'(near(ya, 12, 63));
      end
      last_x = (xa + int'(c.f.x_b)) / 2;
      last_y = (ya + int'(c.f.y_b)) / 2;
    end else if (r < 73) begin
      c.func = FN_BOX;
      if ($urandom_range(0, 4) != 0) begin
        c.f.x_b = 7'($urandom_range(0, 15));
        c.f.y_b = 6'($urandom_range(0, 15));
      end
      last_x = $urandom_range(0, 1) ? xa : near(xa + int'(c.f.x_b), 0, 127);
      last_y = $urandom_range(0, 1) ? ya : near(ya + int'(c.f.y_b), 0, 63);
    end else if (r < 86) begin
      c.func = FN_WRITE;
      last_x = xa;
      last_y = ya;
    end else if (r < 87) begin
      c.func = FN_CLEAR;
    end else begin
      c.func = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
    end
    return c;
  endfunction

  // Driver: bursts with random gaps, optional drain pauses

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk or negedge rst_n) begin : p_drive
    bit take;
    if (!rst_n) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      take = !s_tvalid || s_tready;
      if (s_tvalid && s_tready) render_command(cur);
      if (take) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (cmd_q[0].wait_drain && read_data_q.size() != 0) begin
          s_tvalid <= 1'b0;
        end else begin
          cur = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, cur.f};
          s_tuser  <= cur.func;
          if (cur.rx_hold) hold_toggle <= ~hold_toggle;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 4);
              2:       gap_left = $urandom_range(1, 40);
              default: gap_left = $urandom_range(1, 300);
            endcase
          end
        end
      end
    end
  end

  // Receiver: stall patterns plus one long hold-off on request

  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   mode = 0;
  int   mode_left = 0;

  always @(posedge clk or negedge rst_n) begin : p_recv
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 400);
        end else begin
          mode_left--;
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor

  always @(posedge clk) begin : p_mon
    logic [7:0] exp_byte;
    if (rst_n && m_tvalid && m_tready) begin
      if (read_data_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected read result %02h", m_tdata);
      end else begin
        exp_byte = read_data_q.pop_front();
        if (m_tdata !== exp_byte) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("read_data mismatch: expected %02h, got %02h", exp_byte, m_tdata);
        end
      end
    end
  end

  int cyc = 0;

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : p_main
    cmd_t c;
    foreach (fb_mem[i]) fb_mem[i] = 8'h00;

    cmd_q.push_back(mk(FN_READ,    0,  0,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_PIXEL,   0,  0,   0,  0, 1'b1, 8'h00));
    cmd_q.push_back(mk(FN_PIXEL, 127, 63, 127, 63, 1'b1, 8'hff));
    cmd_q.push_back(mk(FN_READ,    0,  0,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_READ,  127, 56,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_WRITE,   5, 16,   0,  0, 1'b0, 8'ha5));
    cmd_q.push_back(mk(FN_PIXEL,   5, 16,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_READ,    5, 16,   0,  0, 1'b0, 8'h00));
    // shallow line with negative slope, then steep one with negative slope
    cmd_q.push_back(mk(FN_LINE,    0, 63, 127,  0, 1'b1, 8'h00));
    cmd_q.push_back(mk(FN_READ,   64, 24,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_LINE,   10,  0,   3, 63, 1'b1, 8'h00));
    cmd_q.push_back(mk(FN_READ,    6, 32,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_LINE,  127, 40,   0, 40, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_READ,   60, 40,   0,  0, 1'b0, 8'h00));
    // box edges running off the screen
    cmd_q.push_back(mk(FN_BOX,   120, 60, 127, 63, 1'b1, 8'h00));
    cmd_q.push_back(mk(FN_READ,  120, 56,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_BOX,    30, 30,   0,  0, 1'b1, 8'h00));
    cmd_q.push_back(mk(FN_READ,   30, 24,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_SPARE_LO, 127, 63, 127, 63, 1'b1, 8'hff));
    cmd_q.push_back(mk(FN_SPARE_HI,  30, 24,  30, 24, 1'b0, 8'h5a));
    cmd_q.push_back(mk(FN_WRITE, 127, 63,   0,  0, 1'b0, 8'hff));
    cmd_q.push_back(mk(FN_READ,  127, 63,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_CLEAR,   0,  0,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_READ,  127, 56,   0,  0, 1'b0, 8'h00));
    cmd_q.push_back(mk(FN_READ,    0,  0,   0,  0, 1'b0, 8'h00));

    for (int n = 0; n < N_RANDOM; n++) begin
      c = random_cmd();
      if (n == 500 || n == 1100) c.wait_drain = 1'b1;
      if (n == 700) begin
        c.rx_hold = 1'b1;
        cmd_q.push_back(c);
        for (int k = 0; k < 12; k++)
          cmd_q.push_back(mk(FN_READ, $urandom_range(0, 127), $urandom_range(0, 63),
                             $urandom_range(0, 127), $urandom_range(0, 63),
                             $urandom_range(0, 1), $urandom_range(0, 255)));
      end else begin
        cmd_q.push_back(c);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || s_tvalid || read_data_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (err_cnt == 0 && read_data_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
